// ----- hdl/vtpd_pkg.sv -----
// ----------------------------------------------------------------------------
// vtpd_pkg
// Shared widths, types and helpers of the vertex transform / perspective
// divide unit.
// ----------------------------------------------------------------------------
package vtpd_pkg;

    localparam int CoordW  = 32;
    localparam int FracW   = 16;
    localparam int ProdW   = 2 * CoordW;
    localparam int PsumW   = ProdW + 1;
    localparam int SumW    = ProdW + 2;
    localparam int TW      = SumW - FracW;
    localparam int MagW    = TW;
    localparam int RemW    = MagW + 1;
    localparam int QW      = 32;
    localparam int OvfSh   = QW - FracW - 1;
    localparam int NumRegs = 8;
    localparam int RegW    = 64;
    localparam int CfgIdxW = 4;
    localparam int NearEps = 66;
    localparam int NumOut  = 3;
    localparam int TagW    = 2 + NumOut + NumOut * CoordW;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [TW-1:0]     tval_t;
    typedef logic        [MagW-1:0]   mag_t;
    typedef logic        [RegW-1:0]   mat_reg_t;
    typedef logic        [QW-1:0]     quot_t;

    typedef struct packed {
        logic                do_div;
        logic                skip;
        logic [NumOut-1:0]   neg;
        coord_t [NumOut-1:0] sat;
    } div_tag_t;

    localparam mat_reg_t MatReset [NumRegs] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    localparam coord_t CoordMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam coord_t CoordMin = {1'b1, {(CoordW-1){1'b0}}};

    function automatic coord_t mat_entry(input mat_reg_t regs [NumRegs],
                                         input int r, input int c);
        mat_reg_t w;
        w = regs[r * 2 + c / 2];
        return (c % 2 == 1) ? w[RegW-1:CoordW] : w[CoordW-1:0];
    endfunction

    function automatic coord_t sat32(input tval_t v);
        tval_t hi;
        tval_t lo;
        hi = TW'(CoordMax);
        lo = TW'(CoordMin);
        if (v > hi)
            return CoordMax;
        else if (v < lo)
            return CoordMin;
        return v[CoordW-1:0];
    endfunction

endpackage

// ----- hdl/vtpd_xform.sv -----
// ----------------------------------------------------------------------------
// vtpd_xform
// Four-stage row vector times 4x4 matrix: capture, products, pair sums,
// column sums rounded to Q34.16.
// ----------------------------------------------------------------------------
module vtpd_xform (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic                   in_mode,
    input  vtpd_pkg::coord_t [3:0] in_vec,
    input  vtpd_pkg::mat_reg_t     mat [vtpd_pkg::NumRegs],
    output logic                   out_valid,
    output logic                   out_mode,
    output vtpd_pkg::tval_t [3:0]  out_t
);
    import vtpd_pkg::*;

    localparam logic signed [SumW-1:0] RoundBias = SumW'(1) << (FracW - 1);

    logic [3:0]                    valid_reg;
    logic [3:0]                    mode_reg;
    coord_t                        vec_reg [4];
    logic signed [ProdW-1:0]       prod_reg [4][4];
    logic signed [ProdW-1:0]       prod_next [4][4];
    logic signed [PsumW-1:0]       psum_reg [2][4];
    logic signed [SumW-1:0]        sum_w [4];
    tval_t                         t_reg [4];
    coord_t                        m_ent [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m_ent[r][c]     = mat_entry(mat, r, c);
                prod_next[r][c] = ProdW'(vec_reg[r]) * ProdW'(m_ent[r][c]);
            end
        end
        for (int c = 0; c < 4; c++)
            sum_w[c] = SumW'(psum_reg[0][c]) + SumW'(psum_reg[1][c]) + RoundBias;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_reg <= {mode_reg[2:0], in_mode};
            for (int r = 0; r < 4; r++)
                vec_reg[r] <= in_vec[r];
            prod_reg <= prod_next;
            for (int c = 0; c < 4; c++)
            begin
                psum_reg[0][c] <= PsumW'(prod_reg[0][c]) + PsumW'(prod_reg[1][c]);
                psum_reg[1][c] <= PsumW'(prod_reg[2][c]) + PsumW'(prod_reg[3][c]);
                t_reg[c]       <= sum_w[c][SumW-1:FracW];
            end
        end
    end

    assign out_valid = valid_reg[3];
    assign out_mode  = mode_reg[3];

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            out_t[c] = t_reg[c];
    end

endmodule

// ----- hdl/vtpd_div.sv -----
// ----------------------------------------------------------------------------
// vtpd_div
// Pipelined restoring divider, three numerators over one divisor, one
// quotient bit per stage, with a range check stage in front.
// ----------------------------------------------------------------------------
module vtpd_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  vtpd_pkg::mag_t                    in_ud,
    input  vtpd_pkg::mag_t [vtpd_pkg::NumOut-1:0] in_un,
    input  vtpd_pkg::div_tag_t                in_tag,
    output logic                              out_valid,
    output vtpd_pkg::quot_t [vtpd_pkg::NumOut-1:0] out_q,
    output logic [vtpd_pkg::NumOut-1:0]       out_ovf,
    output vtpd_pkg::div_tag_t                out_tag
);
    import vtpd_pkg::*;

    logic [QW:0]                 valid_reg;
    logic [RemW-1:0]             rem_reg  [QW+1][NumOut];
    logic [QW-1:0]               low_reg  [QW+1][NumOut];
    quot_t                       q_reg    [QW+1][NumOut];
    logic [NumOut-1:0]           ovf_reg  [QW+1];
    mag_t                        ud_reg   [QW+1];
    div_tag_t                    tag_reg  [QW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[QW-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ud_reg[0]  <= in_ud;
            tag_reg[0] <= in_tag;
            for (int c = 0; c < NumOut; c++)
            begin
                ovf_reg[0][c]  <= (MagW + OvfSh)'(in_un[c]) >= ((MagW + OvfSh)'(in_ud) << OvfSh);
                rem_reg[0][c]  <= RemW'(in_un[c][MagW-1:OvfSh]);
                low_reg[0][c]  <= {in_un[c][OvfSh-1:0], (QW - OvfSh)'(0)};
                q_reg[0][c]    <= '0;
            end
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_step
        logic [RemW-1:0] shifted [NumOut];
        logic [NumOut-1:0] ge;

        always_comb
        begin
            for (int c = 0; c < NumOut; c++)
            begin
                shifted[c] = {rem_reg[s][c][RemW-2:0], low_reg[s][c][QW-1]};
                ge[c]      = shifted[c] >= RemW'(ud_reg[s]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ud_reg[s+1]  <= ud_reg[s];
                tag_reg[s+1] <= tag_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                for (int c = 0; c < NumOut; c++)
                begin
                    rem_reg[s+1][c] <= ge[c] ? shifted[c] - RemW'(ud_reg[s]) : shifted[c];
                    low_reg[s+1][c] <= {low_reg[s][c][QW-2:0], 1'b0};
                    q_reg[s+1][c]   <= {q_reg[s][c][QW-2:0], ge[c]};
                end
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_ovf   = ovf_reg[QW];
    assign out_tag   = tag_reg[QW];

    always_comb
    begin
        for (int c = 0; c < NumOut; c++)
            out_q[c] = q_reg[QW][c];
    end

endmodule

// ----- hdl/vertex_transform_persp_divide_unit.sv -----
// ----------------------------------------------------------------------------
// vertex_transform_persp_divide_unit
// Q16.16 row vector times 4x4 matrix with optional perspective divide.
//
//   channel  dir  ready      payload
//   s_*      in   s_tready   tdata {in_w, in_z, in_y, in_x}, tuser mode
//   m_*      out  m_tready   tdata {out_z, out_y, out_x}, tuser divide_skipped
//   cfg_*    in   always 1   cfg_index (register 0..7), cfg_data (64 bits)
//
// One vertex per cycle unless stalled; stages: transform, divide, output.
// The quotient pipeline sets the depth: one quotient bit per stage.
// A held m_tready stalls every stage together; nothing is dropped.
// Reset clears the valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module vertex_transform_persp_divide_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [127:0]                  s_tdata,  // in_x, in_y, in_z, in_w
    input  logic                          s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,  // out_x, out_y, out_z
    output logic                          m_tuser,  // divide_skipped
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vtpd_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [vtpd_pkg::RegW-1:0]     cfg_data
);
    import vtpd_pkg::*;

    logic              en;
    mat_reg_t          mat_reg [NumRegs];
    coord_t [3:0]      in_vec;
    logic              xf_valid;
    logic              xf_mode;
    tval_t [3:0]       xf_t;
    mag_t  [3:0]       mag;
    logic              p_skip;
    div_tag_t          p_tag;
    logic              dv_valid;
    quot_t [NumOut-1:0] dv_q;
    logic [NumOut-1:0] dv_ovf;
    div_tag_t          dv_tag;
    logic [QW:0]       rnd [NumOut];
    coord_t [NumOut-1:0] res_next;
    logic              vo_reg;
    logic [95:0]       data_reg;
    logic              skip_reg;

    assign en        = !vo_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mat_reg <= MatReset;
        else if (cfg_valid && cfg_index < CfgIdxW'(NumRegs))
            mat_reg[cfg_index[$clog2(NumRegs)-1:0]] <= cfg_data;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            in_vec[i] = s_tdata[i*CoordW +: CoordW];
    end

    vtpd_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .in_mode   (s_tuser),
        .in_vec    (in_vec),
        .mat       (mat_reg),
        .out_valid (xf_valid),
        .out_mode  (xf_mode),
        .out_t     (xf_t)
    );

    always_comb
    begin
        for (int c = 0; c < 4; c++)
            mag[c] = xf_t[c][TW-1] ? MagW'(-xf_t[c]) : MagW'(xf_t[c]);
        p_skip       = xf_mode && (mag[3] <= MagW'(NearEps));
        p_tag.do_div = xf_mode && !p_skip;
        p_tag.skip   = p_skip;
        for (int c = 0; c < NumOut; c++)
        begin
            p_tag.neg[c] = xf_t[c][TW-1] != xf_t[3][TW-1];
            p_tag.sat[c] = sat32(xf_t[c]);
        end
    end

    vtpd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xf_valid),
        .in_ud     (mag[3]),
        .in_un     (mag[NumOut-1:0]),
        .in_tag    (p_tag),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_ovf   (dv_ovf),
        .out_tag   (dv_tag)
    );

    always_comb
    begin
        for (int c = 0; c < NumOut; c++)
        begin
            rnd[c] = ((QW + 1)'(dv_q[c]) + (QW + 1)'(1)) >> 1;
            if (!dv_tag.do_div)
                res_next[c] = dv_tag.sat[c];
            else if (dv_ovf[c])
                res_next[c] = dv_tag.neg[c] ? CoordMin : CoordMax;
            else if (dv_tag.neg[c])
                res_next[c] = (rnd[c] > (QW + 1)'(32'h8000_0000)) ? CoordMin
                                                                  : -rnd[c][CoordW-1:0];
            else
                res_next[c] = (rnd[c] > (QW + 1)'(CoordMax)) ? CoordMax
                                                             : rnd[c][CoordW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= res_next;
            skip_reg <= dv_tag.skip;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = skip_reg;

    a_skip_needs_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (xf_valid && p_skip) |-> xf_mode)
        else $error("skip flagged without divide mode");

    a_div_skip_excl: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid |-> !(dv_tag.do_div && dv_tag.skip))
        else $error("divide and skip both set");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without pending output");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for vertex_transform_persp_divide_unit. Runs directed vertices
// through the identity and other matrices, near-zero w cases and saturation.
// Then it sweeps random matrices, including extreme ones, and random vertices
// under several idle and stall mixes. An internal predictor computes each
// expected vertex, and every output transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    import vtpd_pkg::*;

    localparam int RegR0C01   = 0;
    localparam int RegR3C23   = 7;
    localparam int RegUnused  = 9;
    localparam int DrainWait  = 60;
    localparam int WatchLimit = 20000;
    localparam logic signed [67:0] Q32Max = 68'sd2147483647;
    localparam logic signed [67:0] Q32Min = -68'sd2147483648;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   skipped;
    } vertex_out_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [127:0]       s_tdata;    // in_x, in_y, in_z, in_w
    logic               s_tuser;    // mode
    logic               m_tvalid;
    logic               m_tready;
    logic [95:0]        m_tdata;    // out_x, out_y, out_z
    logic               m_tuser;    // divide_skipped
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [RegW-1:0]    cfg_data;

    mat_reg_t    matrix [NumRegs];
    vertex_out_t vertex_q [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatches;
    int          vertices_checked;
    int          skips_seen;
    int          quiet_cycles;

    vertex_transform_persp_divide_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic signed [67:0] column_sum(input coord_t v [4], input int c);
        logic signed [67:0] acc;
        logic signed [67:0] a;
        logic signed [67:0] b;
        mat_reg_t           r;
        acc = '0;
        for (int i = 0; i < 4; i++)
        begin
            r = matrix[i * 2 + c / 2];
            a = v[i];
            b = (c % 2 == 1) ? coord_t'(r[63:32]) : coord_t'(r[31:0]);
            acc += a * b;
        end
        return (acc + 68'sd32768) >>> FracW;
    endfunction

    function automatic coord_t clamp_q16(input logic signed [67:0] v);
        if (v > Q32Max)
            return CoordMax;
        if (v < Q32Min)
            return CoordMin;
        return v[31:0];
    endfunction

    function automatic coord_t divide_q16(input logic signed [67:0] n,
                                          input logic signed [67:0] d);
        logic         neg;
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        neg = n[67] ^ d[67];
        un = n[67] ? 128'(-n) : 128'(n);
        ud = d[67] ? 128'(-d) : 128'(d);
        if (un / ud >= 128'd32768)
            return neg ? CoordMin : CoordMax;
        q = (((un << 17) / ud) + 128'd1) >> 1;
        if (neg)
        begin
            if (q > 128'd2147483648)
                q = 128'd2147483648;
            return coord_t'(-q[31:0]);
        end
        if (q > 128'd2147483647)
            q = 128'd2147483647;
        return q[31:0];
    endfunction

    function automatic vertex_out_t transform_vertex(input logic mode, input coord_t x,
                                                     input coord_t y, input coord_t z,
                                                     input coord_t w);
        coord_t             v [4];
        logic signed [67:0] t [4];
        vertex_out_t        o;
        logic               do_div;
        v = '{x, y, z, w};
        for (int c = 0; c < 4; c++)
            t[c] = column_sum(v, c);
        o.skipped = mode && (t[3] <= 68'sd66) && (t[3] >= -68'sd66);
        do_div = mode && !o.skipped;
        o.x = do_div ? divide_q16(t[0], t[3]) : clamp_q16(t[0]);
        o.y = do_div ? divide_q16(t[1], t[3]) : clamp_q16(t[1]);
        o.z = do_div ? divide_q16(t[2], t[3]) : clamp_q16(t[2]);
        return o;
    endfunction

    task automatic send_vertex(input logic mode, input coord_t x, input coord_t y,
                               input coord_t z, input coord_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {w, z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        vertex_q.push_back(transform_vertex(mode, x, y, z, w));
    endtask

    task automatic write_reg(input int idx, input mat_reg_t value);
        @(negedge clk);
        s_tvalid  = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx[CfgIdxW-1:0];
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < NumRegs)
            matrix[idx] = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (vertex_q.size() == 0);
        repeat (DrainWait) @(posedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
            2:       return $urandom_range(1) ? CoordMax : CoordMin;
            3:       return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            default: return $signed($urandom_range(400)) - 200;
        endcase
    endfunction

    function automatic mat_reg_t rand_entry_pair();
        coord_t lo;
        coord_t hi;
        lo = rand_coord();
        hi = rand_coord();
        if ($urandom_range(3) == 0)
            lo = 32'sh0001_0000;
        return {hi, lo};
    endfunction

    task automatic load_identity;
        for (int i = RegR0C01; i <= RegR3C23; i++)
            write_reg(i, MatReset[i]);
    endtask

    task automatic test_identity_directed;
        send_vertex(1'b0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh0001_0000);
        send_vertex(1'b0, CoordMax, CoordMin, 32'sd0, CoordMax);
        send_vertex(1'b0, CoordMin, CoordMax, -32'sd1, CoordMin);
        send_vertex(1'b1, 32'sh0004_0000, -32'sh0006_0000, 32'sh0001_8000, 32'sh0002_0000);
        send_vertex(1'b1, 32'sd3, -32'sd5, 32'sd1, 32'sd131072);
        send_vertex(1'b1, CoordMax, CoordMin, 32'sd1, 32'sd67);
        send_vertex(1'b1, CoordMin, CoordMax, CoordMax, CoordMin);
        send_vertex(1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sh7FFF_0000);
    endtask

    task automatic test_near_zero_w;
        send_vertex(1'b1, 32'sh0001_0000, 32'sh0002_0000, -32'sd7, 32'sd66);
        send_vertex(1'b1, 32'sh0001_0000, 32'sh0002_0000, -32'sd7, -32'sd66);
        send_vertex(1'b1, 32'sh0001_0000, 32'sh0002_0000, -32'sd7, 32'sd0);
        send_vertex(1'b1, 32'sh0001_0000, 32'sh0002_0000, -32'sd7, 32'sd67);
        send_vertex(1'b1, 32'sh0001_0000, 32'sh0002_0000, -32'sd7, -32'sd67);
        send_vertex(1'b0, 32'sh0001_0000, 32'sh0002_0000, -32'sd7, 32'sd0);
    endtask

    task automatic test_saturation;
        drain();
        for (int i = RegR0C01; i <= RegR3C23; i++)
            write_reg(i, {CoordMax, CoordMax});
        send_vertex(1'b0, CoordMax, CoordMax, CoordMax, CoordMax);
        send_vertex(1'b0, CoordMin, CoordMin, CoordMin, CoordMin);
        send_vertex(1'b1, CoordMax, CoordMin, CoordMax, 32'sd1);
        drain();
        for (int i = RegR0C01; i <= RegR3C23; i++)
            write_reg(i, {CoordMin, CoordMin});
        send_vertex(1'b0, CoordMin, CoordMin, CoordMin, CoordMin);
        send_vertex(1'b1, CoordMax, 32'sd0, 32'sd0, 32'sd0);
        send_vertex(1'b1, 32'sd1, 32'sd1, -32'sd1, 32'sd0);
        drain();
        write_reg(RegUnused, '1);
        load_identity();
    endtask

    task automatic run_random_set(input int count, input logic near_zero_w);
        coord_t w;
        for (int n = 0; n < count; n++)
        begin
            w = near_zero_w ? coord_t'($signed($urandom_range(300)) - 150) : rand_coord();
            send_vertex($urandom_range(3) != 0, rand_coord(), rand_coord(), rand_coord(), w);
        end
    endtask

    task automatic test_random_sweep;
        int idle_mix  [4] = '{0, 53, 0, 12};
        int stall_mix [4] = '{0, 0, 53, 12};
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_mix[p];
            recv_stall_pct = stall_mix[p];
            drain();
            load_identity();
            run_random_set(60, 1'b1);
            for (int m = 0; m < 3; m++)
            begin
                drain();
                for (int i = RegR0C01; i <= RegR3C23; i++)
                    write_reg(i, rand_entry_pair());
                run_random_set(80, 1'b0);
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        vertex_out_t want;
        coord_t      gx;
        coord_t      gy;
        coord_t      gz;
        if (rst_n && m_tvalid && m_tready)
        begin
            gx = m_tdata[31:0];
            gy = m_tdata[63:32];
            gz = m_tdata[95:64];
            if (vertex_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected vertex x=%0d y=%0d z=%0d skip=%0b",
                             gx, gy, gz, m_tuser);
            end
            else
            begin
                want = vertex_q.pop_front();
                vertices_checked++;
                if (want.skipped)
                    skips_seen++;
                if (gx !== want.x || gy !== want.y || gz !== want.z
                    || m_tuser !== want.skipped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"tb: vertex %0d exp x=%0d y=%0d z=%0d skip=%0b",
                                  " got x=%0d y=%0d z=%0d skip=%0b"},
                                 vertices_checked, want.x, want.y, want.z, want.skipped,
                                 gx, gy, gz, m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        m_tready         = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        mismatches       = 0;
        vertices_checked = 0;
        skips_seen       = 0;
        quiet_cycles     = 0;
        for (int i = 0; i < NumRegs; i++)
            matrix[i] = MatReset[i];
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_identity_directed();
        test_near_zero_w();
        test_saturation();
        test_random_sweep();
        drain();

        $display("tb: %0d vertices checked, %0d with skipped divide, %0d mismatches",
                 vertices_checked, skips_seen, mismatches);
        $display("tb: covered identity, extreme and random matrices under idle/stall mixes");
        if (mismatches == 0 && vertex_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- vertex_transform_persp_divide_unit.f -----
hdl/vtpd_pkg.sv
hdl/vtpd_xform.sv
hdl/vtpd_div.sv
hdl/vertex_transform_persp_divide_unit.sv
tb/tb.sv
